>>> sv/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared constants and types of the maze row generator: the default column
// count and the control word that the sequencer hands to every label cell.
// ----------------------------------------------------------------------------
package mrg_pkg;

  localparam int COLUMNS_DEF = 16;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_LOAD   = 3'd1,
    CELL_JOIN   = 3'd2,
    CELL_MARK   = 3'd3,
    CELL_ROTATE = 3'd4,
    CELL_RELOAD = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     merge;
  } mrg_ctrl_t;

endpackage

>>> sv/maze_row_generator_top.sv
// ----------------------------------------------------------------------------
// maze_row_generator_top
// Eller-style maze generator producing one maze row per input word.
// ----------------------------------------------------------------------------
// The set labels live in a ring of COLUMNS cells that rotates by one column
// per cycle while the join scan or the label assignment runs. A row passes
// these steps from acceptance to a result in the output register: accept,
// a join scan over one full rotation with row-wide relabelling at the head
// of the ring, marking the cells that open down, collecting the labels in
// use, a second rotation in which closed cells receive fresh labels from a
// lowest-free-label encoder, and loading the output register. A last row
// skips marking, collecting and the second rotation. The result sits in an
// output register, so the next row is accepted while the previous result
// waits.
// ----------------------------------------------------------------------------
module maze_row_generator_top import mrg_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [$clog2(COLUMNS):0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COLUMNS-2:0]            in_join_bits,
  input  logic [COLUMNS-1:0]            in_drop_bits,
  input  logic                          in_last_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COLUMNS-2:0]            out_right_walls,
  output logic [COLUMNS-1:0]            out_bottom_walls
);

  localparam int LW = $clog2(COLUMNS);
  localparam int NW = $clog2(COLUMNS) + 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_JOIN   = 6'b000010,
    ST_MARK   = 6'b000100,
    ST_USED   = 6'b001000,
    ST_ASSIGN = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [NW-1:0]      cols_r;
  logic [NW-1:0]      ncl;
  logic [LW-1:0]      cnt_r;
  logic               cnt_end;
  logic [COLUMNS-2:0] join_r;
  logic [COLUMNS-1:0] drop_r;
  logic               last_r;
  logic [COLUMNS-1:0] wall_r;
  logic [COLUMNS-1:0] used_r;
  logic [COLUMNS-1:0] used_c;
  logic [LW-1:0]      fresh;
  logic               out_valid_r;
  logic [COLUMNS-2:0] out_right_r;
  logic [COLUMNS-1:0] out_bottom_r;
  logic               accept;
  logic               out_free;

  mrg_ctrl_t          ctrl;
  logic [LW-1:0]      a_lab, b_lab, m_lab;
  logic               merge;
  logic               assign_now;
  logic [LW-1:0]      lab     [COLUMNS];
  logic [LW-1:0]      nb_lab  [COLUMNS];
  logic [COLUMNS-1:0] act, opn, nb_act, nb_opn;
  logic [COLUMNS-1:0] load_act;
  logic [COLUMNS-1:0] rightmost;
  logic [COLUMNS-1:0] mark;

  // Column count, clamped to the range the ring supports.
  always_comb begin
    if (cols_r < NW'(2)) begin
      ncl = NW'(2);
    end else if (cols_r > NW'(COLUMNS)) begin
      ncl = NW'(COLUMNS);
    end else begin
      ncl = cols_r;
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign cnt_end  = (cnt_r == LW'(COLUMNS - 1));

  // Join decision at the head of the ring: cells 0 and 1 hold columns j, j+1.
  assign a_lab = lab[0];
  assign b_lab = lab[1];
  assign m_lab = (a_lab < b_lab) ? a_lab : b_lab;
  assign merge = (state_r == ST_JOIN) && !cnt_end && act[1] && (a_lab != b_lab) &&
                 (last_r || join_r[0]);

  // A closed in-use cell leaving the head takes the lowest free label.
  assign assign_now = (state_r == ST_ASSIGN) && act[0] && !opn[0];

  always_comb begin
    fresh = '0;
    for (int i = COLUMNS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        fresh = LW'(i);
      end
    end
  end

  always_comb begin
    used_c = '0;
    for (int p = 0; p < COLUMNS; p++) begin
      if (opn[p]) begin
        used_c[lab[p]] = 1'b1;
      end
    end
  end

  // Neighbor wiring of the ring; the wrap path carries the fresh label.
  always_comb begin
    for (int p = 0; p < COLUMNS - 1; p++) begin
      nb_lab[p] = lab[p+1];
    end
    nb_lab[COLUMNS-1] = assign_now ? fresh : lab[0];
    nb_act = {act[0], act[COLUMNS-1:1]};
    nb_opn = {opn[0], opn[COLUMNS-1:1]};
  end

  assign mark = drop_r | rightmost;

  always_comb begin
    ctrl.merge = merge;
    ctrl.op    = CELL_HOLD;
    unique case (state_r)
      ST_IDLE:   ctrl.op = accept ? CELL_LOAD : CELL_HOLD;
      ST_JOIN:   ctrl.op = CELL_JOIN;
      ST_MARK:   ctrl.op = CELL_MARK;
      ST_USED:   ctrl.op = CELL_HOLD;
      ST_ASSIGN: ctrl.op = CELL_ROTATE;
      ST_DONE:   ctrl.op = last_r ? CELL_RELOAD : CELL_HOLD;
      default:   ctrl.op = CELL_HOLD;
    endcase
  end

  for (genvar p = 0; p < COLUMNS; p++) begin : g_cell
    assign load_act[p] = (NW'(p) < ncl);

    mrg_cell #(
      .LW    (LW),
      .INDEX (p)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl_i        (ctrl),
      .a_i           (a_lab),
      .b_i           (b_lab),
      .m_i           (m_lab),
      .load_active_i (load_act[p]),
      .mark_i        (mark[p]),
      .nb_label_i    (nb_lab[p]),
      .nb_active_i   (nb_act[p]),
      .nb_open_i     (nb_opn[p]),
      .label_o       (lab[p]),
      .active_o      (act[p]),
      .open_o        (opn[p])
    );
  end

  mrg_rightmost #(
    .COLUMNS (COLUMNS),
    .LW      (LW)
  ) u_rightmost (
    .label_i     (lab),
    .active_i    (act),
    .rightmost_o (rightmost)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_JOIN;
      ST_JOIN:   if (cnt_end) state_nxt = last_r ? ST_DONE : ST_MARK;
      ST_MARK:   state_nxt = ST_USED;
      ST_USED:   state_nxt = ST_ASSIGN;
      ST_ASSIGN: if (cnt_end) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cols_r      <= NW'(COLUMNS);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cols_r <= cfg_wr_data;
      end
      if ((state_r == ST_JOIN) || (state_r == ST_ASSIGN)) begin
        cnt_r <= cnt_end ? '0 : cnt_r + LW'(1);
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      join_r <= in_join_bits;
      drop_r <= in_drop_bits;
      last_r <= in_last_row;
    end else if (state_r == ST_JOIN) begin
      join_r <= join_r >> 1;
    end
    // After a full rotation the wall decided at step j sits in bit j.
    if (state_r == ST_JOIN) begin
      wall_r <= {~merge, wall_r[COLUMNS-1:1]};
    end
    if (state_r == ST_USED) begin
      used_r <= used_c;
    end else if (assign_now) begin
      used_r[fresh] <= 1'b1;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_right_r  <= wall_r[COLUMNS-2:0];
      out_bottom_r <= last_r ? '1 : ~opn;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_right_walls  = out_right_r;
  assign out_bottom_walls = out_bottom_r;

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (cnt_r == '0))
    else $error("label ring not back in column order at mark");

  a_label_free: assert property (@(posedge clk) disable iff (!rst_n)
    assign_now |-> !(&used_r))
    else $error("no free label for a closed cell");

  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && last_r) |=> (lab[COLUMNS-1] == LW'(COLUMNS - 1)))
    else $error("labels not restored after the last row");

endmodule

>>> sv/mrg_cell.sv
// ----------------------------------------------------------------------------
// mrg_cell
// One position of the label ring. Holds a set label, an in-use flag and an
// open-down flag, and takes its neighbor's contents when the ring rotates.
// ----------------------------------------------------------------------------
module mrg_cell import mrg_pkg::*; #(
  parameter int LW    = $clog2(COLUMNS_DEF),
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mrg_ctrl_t     ctrl_i,
  input  logic [LW-1:0] a_i,
  input  logic [LW-1:0] b_i,
  input  logic [LW-1:0] m_i,
  input  logic          load_active_i,
  input  logic          mark_i,
  input  logic [LW-1:0] nb_label_i,
  input  logic          nb_active_i,
  input  logic          nb_open_i,
  output logic [LW-1:0] label_o,
  output logic          active_o,
  output logic          open_o
);

  logic [LW-1:0] label_r;
  logic          active_r;
  logic          open_r;
  logic          hit;

  // The incoming label belongs to one of the two sets being merged.
  assign hit = ctrl_i.merge && nb_active_i && ((nb_label_i == a_i) || (nb_label_i == b_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r  <= LW'(INDEX);
      active_r <= 1'b0;
      open_r   <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        CELL_HOLD: begin
        end
        CELL_LOAD: begin
          active_r <= load_active_i;
          open_r   <= 1'b0;
        end
        CELL_JOIN: begin
          label_r  <= hit ? m_i : nb_label_i;
          active_r <= nb_active_i;
          open_r   <= nb_open_i;
        end
        CELL_MARK: begin
          open_r <= active_r & mark_i;
        end
        CELL_ROTATE: begin
          label_r  <= nb_label_i;
          active_r <= nb_active_i;
          open_r   <= nb_open_i;
        end
        CELL_RELOAD: begin
          label_r <= LW'(INDEX);
        end
        default: begin
        end
      endcase
    end
  end

  assign label_o  = label_r;
  assign active_o = active_r;
  assign open_o   = open_r;

endmodule

>>> sv/mrg_rightmost.sv
// ----------------------------------------------------------------------------
// mrg_rightmost
// Flags every column that is the rightmost in-use member of its set, by
// comparing its label with the labels of all in-use columns to its right.
// ----------------------------------------------------------------------------
module mrg_rightmost import mrg_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int LW      = $clog2(COLUMNS)
) (
  input  logic [LW-1:0]      label_i [COLUMNS],
  input  logic [COLUMNS-1:0] active_i,
  output logic [COLUMNS-1:0] rightmost_o
);

  always_comb begin
    for (int p = 0; p < COLUMNS; p++) begin
      rightmost_o[p] = 1'b1;
      for (int k = 0; k < COLUMNS; k++) begin
        if ((k > p) && active_i[k] && (label_i[k] == label_i[p])) begin
          rightmost_o[p] = 1'b0;
        end
      end
    end
  end

endmodule

>>> tb/tb_maze_row_generator_top.sv
// ----------------------------------------------------------------------------
// tb_maze_row_generator_top
// Self-checking bench for the maze row generator. A behavioral copy of the
// set-label state predicts the wall pattern of every accepted row. The bench
// drives directed corner rows, column-count limits and a long output stall.
// It then runs random mazes under random sender bursts and receiver stalls,
// and checks each result word field by field.
// ----------------------------------------------------------------------------
module tb_maze_row_generator_top import mrg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS         = COLUMNS_DEF;
  localparam int ROW_TARGET   = 1240;
  localparam int LATENCY      = 2 * COLS + 8;
  localparam int SETTLE       = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [COLS-2:0] right_walls;
    logic [COLS-1:0] bottom_walls;
  } row_walls_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [$clog2(COLS):0] cfg_wr_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [COLS-2:0]       in_join_bits;
  logic [COLS-1:0]       in_drop_bits;
  logic                  in_last_row;
  logic                  out_valid;
  logic                  out_ready;
  logic [COLS-2:0]       out_right_walls;
  logic [COLS-1:0]       out_bottom_walls;

  // Predicted set labels and the column-count register.
  logic [3:0]            set_label [COLS];
  logic [$clog2(COLS):0] col_reg;

  row_walls_t expected_rows[$];
  int mismatch_count = 0;
  int rows_sent = 0;
  int rows_checked = 0;
  int mazes_done = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_on = 1'b0;

  maze_row_generator_top #(.COLUMNS(COLS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_join_bits     (in_join_bits),
    .in_drop_bits     (in_drop_bits),
    .in_last_row      (in_last_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_right_walls  (out_right_walls),
    .out_bottom_walls (out_bottom_walls)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reset_labels();
    for (int j = 0; j < COLS; j++) begin
      set_label[j] = 4'(j);
    end
  endfunction

  // Walls of one row and the labels that the next row inherits.
  function automatic void build_row(input logic [COLS-2:0] join_mask,
                                    input logic [COLS-1:0] drop_mask,
                                    input logic last,
                                    output logic [COLS-2:0] right_w,
                                    output logic [COLS-1:0] bottom_w);
    int n;
    int k;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] m;
    bit opens [COLS];
    bit taken [COLS];
    bit rightmost;
    n = (col_reg < 2) ? 2 : ((col_reg > COLS) ? COLS : int'(col_reg));
    right_w = '1;
    bottom_w = '1;
    for (int j = 0; j + 1 < n; j++) begin
      a = set_label[j];
      b = set_label[j+1];
      if (a != b && (last || join_mask[j])) begin
        m = (a < b) ? a : b;
        for (int c = 0; c < n; c++) begin
          if (set_label[c] == a || set_label[c] == b) set_label[c] = m;
        end
        right_w[j] = 1'b0;
      end
    end
    if (last) begin
      reset_labels();
      return;
    end
    for (int j = 0; j < n; j++) begin
      rightmost = 1'b1;
      for (int c = j + 1; c < n; c++) begin
        if (set_label[c] == set_label[j]) rightmost = 1'b0;
      end
      opens[j] = rightmost || drop_mask[j];
      if (opens[j]) bottom_w[j] = 1'b0;
    end
    for (int j = 0; j < COLS; j++) taken[j] = 1'b0;
    for (int j = 0; j < n; j++) begin
      if (opens[j]) taken[set_label[j]] = 1'b1;
    end
    // Closed cells take the lowest free labels, left to right.
    k = 0;
    for (int j = 0; j < n; j++) begin
      if (!opens[j]) begin
        while (k < COLS && taken[k]) k++;
        if (k < COLS) begin
          set_label[j] = 4'(k);
          taken[k] = 1'b1;
        end
      end
    end
  endfunction

  function automatic logic [COLS-1:0] rand_mask();
    logic [COLS-1:0] x;
    logic [COLS-1:0] y;
    x = COLS'($urandom);
    y = COLS'($urandom);
    unique case ($urandom_range(0, 3))
      0: return x & y;
      1: return x | y;
      default: return x;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back words need no gap.
  task automatic push_row(input logic [COLS-2:0] join_mask,
                          input logic [COLS-1:0] drop_mask,
                          input logic last);
    row_walls_t want;
    in_valid     <= 1'b1;
    in_join_bits <= join_mask;
    in_drop_bits <= drop_mask;
    in_last_row  <= last;
    do @(posedge clk); while (!in_ready);
    build_row(join_mask, drop_mask, last, want.right_walls, want.bottom_walls);
    expected_rows.push_back(want);
    rows_sent++;
    if (last) mazes_done++;
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_rows();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_columns(input logic [$clog2(COLS):0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    col_reg = value;
    cfg_writes++;
  endtask

  task automatic test_reset_rows();
    push_row('0, '0, 1'b0);
    push_row('1, '0, 1'b0);
    push_row(15'h5555, 16'hAAAA, 1'b0);
    push_row('1, '1, 1'b0);
    push_row('0, '0, 1'b1);
    push_row('0, '0, 1'b1);
    push_row('1, '1, 1'b1);
    drain_rows();
  endtask

  // Covers the clamp at both ends of the column count.
  task automatic test_column_limits();
    logic [$clog2(COLS):0] settings [6];
    settings = '{5'd2, 5'd0, 5'd1, 5'd31, 5'd17, 5'd16};
    foreach (settings[i]) begin
      set_columns(settings[i]);
      push_row('1, '0, 1'b0);
      push_row('0, '1, 1'b1);
      drain_rows();
    end
  endtask

  // The receiver holds off while words keep coming, so the block backs up.
  task automatic test_long_stall();
    hold_req = 1'b1;
    wait (hold_on);
    repeat (10) push_row((COLS-1)'(rand_mask()), rand_mask(),
                         ($urandom_range(0, 4) == 0));
    drain_rows();
  endtask

  task automatic test_random_mazes();
    int burst_left;
    int maze_rows;
    logic last;
    burst_left = $urandom_range(1, 12);
    while (rows_sent < ROW_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        drain_rows();
        if ($urandom_range(0, 3) == 0) begin
          set_columns(($clog2(COLS)+1)'($urandom_range(0, 31)));
        end else begin
          set_columns(($clog2(COLS)+1)'($urandom_range(2, COLS)));
        end
      end
      maze_rows = $urandom_range(1, 16);
      for (int r = 0; r < maze_rows; r++) begin
        // Mostly complete mazes; now and then one ends early or never ends.
        if (r == maze_rows - 1) last = ($urandom_range(0, 9) != 0);
        else last = ($urandom_range(0, 24) == 0);
        push_row((COLS-1)'(rand_mask()), rand_mask(), last);
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 30));
          if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 60);
          else burst_left = $urandom_range(1, 12);
        end
      end
    end
  endtask

  // Receiver stall pattern: runs of always-ready, coin-flip and mostly-stalled.
  initial begin : sink_pattern
    int mode;
    int run_len;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_on = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        run_len = $urandom_range(4, 60);
        repeat (run_len) begin
          @(negedge clk);
          unique case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_rows
    row_walls_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, right_walls %h bottom_walls %h",
                 $time, out_right_walls, out_bottom_walls);
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (out_right_walls !== want.right_walls) begin
          mismatch_count++;
          $display("%0t: right_walls expected %h, actual %h",
                   $time, want.right_walls, out_right_walls);
        end
        if (out_bottom_walls !== want.bottom_walls) begin
          mismatch_count++;
          $display("%0t: bottom_walls expected %h, actual %h",
                   $time, want.bottom_walls, out_bottom_walls);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_maze_row_generator_top: done, errors");
      $finish;
    end
  end

  initial begin : run_tests
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_join_bits = '0;
    in_drop_bits = '0;
    in_last_row  = 1'b0;
    col_reg      = 5'd16;
    reset_labels();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_rows();
    test_column_limits();
    test_long_stall();
    test_random_mazes();
    drain_rows();
    repeat (LATENCY) @(negedge clk);

    $display("Checked %0d rows over %0d finished mazes, with %0d column-count writes",
             rows_checked, mazes_done, cfg_writes);
    $display("including clamped counts, a long output stall and random flow control.");
    if (mismatch_count == 0) begin
      $display("tb_maze_row_generator_top: done, clean");
    end else begin
      $display("tb_maze_row_generator_top: done, errors");
    end
    $finish;
  end

endmodule
